// ----- rtl/trcl_pkg.sv -----
// Shared constants, command codes, state encoding and control structs of the token ledger.
package trcl_pkg;

  localparam int unsigned MaxTokens     = 64;
  localparam int unsigned MaxTokenBytes = 1024;
  localparam int unsigned MaxDesc       = 16;

  localparam int unsigned DescIdxW = 4;
  localparam int unsigned TokIdxW  = 6;
  localparam int unsigned CntW     = 11;
  localparam int unsigned PosW     = 17;
  localparam int unsigned RowW     = 10;
  localparam int unsigned BitW     = 6;
  localparam int unsigned TallyW   = 5;

  typedef enum logic [1:0] {
    CMD_ACCEPT   = 2'd0,
    CMD_BURST    = 2'd1,
    CMD_TERMINAL = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_e;

  typedef enum logic [0:0] {
    REG_TOKENS = 1'b0,
    REG_BYTES  = 1'b1
  } reg_e;

  typedef enum logic [10:0] {
    ST_CLEAR  = 11'b000_0000_0001,
    ST_IDLE   = 11'b000_0000_0010,
    ST_LOOKUP = 11'b000_0000_0100,
    ST_EXEC   = 11'b000_0000_1000,
    ST_BMUL   = 11'b000_0001_0000,
    ST_BLIM   = 11'b000_0010_0000,
    ST_BSTEP  = 11'b000_0100_0000,
    ST_BWR    = 11'b000_1000_0000,
    ST_SWEEP  = 11'b001_0000_0000,
    ST_DRAIN  = 11'b010_0000_0000,
    ST_DONE   = 11'b100_0000_0000
  } state_e;

  typedef struct packed {
    logic clr_row;
    logic start;
    logic lookup;
    logic exec;
    logic bmul;
    logic blim;
    logic brd;
    logic adv;
    logic bwr;
    logic sweep_rd;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_burst;
    logic burst_go;
    logic c_end;
    logic c_in;
    logic sweep_last;
    logic out_busy;
  } dp_status_t;

endpackage

// ----- rtl/trcl_ctrl.sv -----
// Controller state machine sequencing lookup, update, burst walk and bitmap sweep.
module trcl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  trcl_pkg::dp_status_t stat_i,
  output trcl_pkg::ctrl_cmd_t  cmd_o
);

  trcl_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= trcl_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      trcl_pkg::ST_CLEAR: begin
        cmd_o.clr_row = 1'b1;
        if (stat_i.clr_last) state_d = trcl_pkg::ST_IDLE;
      end
      trcl_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_o.start = 1'b1;
          state_d     = trcl_pkg::ST_LOOKUP;
        end
      end
      trcl_pkg::ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = trcl_pkg::ST_EXEC;
      end
      trcl_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (stat_i.is_burst && stat_i.burst_go) state_d = trcl_pkg::ST_BMUL;
        else state_d = trcl_pkg::ST_SWEEP;
      end
      trcl_pkg::ST_BMUL: begin
        cmd_o.bmul = 1'b1;
        state_d    = trcl_pkg::ST_BLIM;
      end
      trcl_pkg::ST_BLIM: begin
        cmd_o.blim = 1'b1;
        state_d    = trcl_pkg::ST_BSTEP;
      end
      trcl_pkg::ST_BSTEP: begin
        priority if (stat_i.c_end) begin
          state_d = trcl_pkg::ST_SWEEP;
        end else if (stat_i.c_in) begin
          cmd_o.brd = 1'b1;
          state_d   = trcl_pkg::ST_BWR;
        end else begin
          cmd_o.adv = 1'b1;
        end
      end
      trcl_pkg::ST_BWR: begin
        cmd_o.bwr = 1'b1;
        cmd_o.adv = 1'b1;
        state_d   = trcl_pkg::ST_BSTEP;
      end
      trcl_pkg::ST_SWEEP: begin
        cmd_o.sweep_rd = 1'b1;
        if (stat_i.sweep_last) state_d = trcl_pkg::ST_DRAIN;
      end
      trcl_pkg::ST_DRAIN: begin
        state_d = trcl_pkg::ST_DONE;
      end
      trcl_pkg::ST_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = trcl_pkg::ST_IDLE;
        end
      end
      default: state_d = trcl_pkg::ST_CLEAR;
    endcase
  end

  assign s_axis_tready = (state_q == trcl_pkg::ST_IDLE);

endmodule

// ----- rtl/trcl_dp.sv -----
// Datapath: descriptor table, byte map and commit count memories, sweep and result register.
module trcl_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [0:0]           cfg_idx_i,
  input  logic [10:0]          cfg_data_i,
  input  logic [1:0]           in_cmd_i,
  input  logic [31:0]          in_id_i,
  input  logic [31:0]          in_first_i,
  input  logic [31:0]          in_cnt_i,
  input  logic [19:0]          in_off_i,
  input  logic [19:0]          in_len_i,
  input  logic                 in_ok_i,
  input  trcl_pkg::ctrl_cmd_t  cmd_i,
  output trcl_pkg::dp_status_t stat_o,
  input  logic                 m_axis_tready,
  output logic                 m_axis_tvalid,
  output logic [87:0]          m_axis_tdata
);

  localparam int unsigned ND = trcl_pkg::MaxDesc;
  localparam int unsigned NT = trcl_pkg::MaxTokens;

  // Configuration.
  logic [6:0]  cfg_a_q;
  logic [10:0] cfg_b_q;
  logic [6:0]  a_eff;
  logic [10:0] b_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_a_q <= 7'd64;
      cfg_b_q <= 11'd64;
    end else if (cfg_we_i) begin
      unique case (trcl_pkg::reg_e'(cfg_idx_i))
        trcl_pkg::REG_TOKENS: cfg_a_q <= cfg_data_i[6:0];
        trcl_pkg::REG_BYTES:  cfg_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign a_eff = (cfg_a_q > 7'(trcl_pkg::MaxTokens)) ? 7'(trcl_pkg::MaxTokens) : cfg_a_q;
  assign b_eff = (cfg_b_q > 11'(trcl_pkg::MaxTokenBytes)) ?
                 11'(trcl_pkg::MaxTokenBytes) : cfg_b_q;

  // Latched input item.
  trcl_pkg::cmd_e cmd_q;
  logic [31:0] id_q, first_q, cnt_q;
  logic [19:0] off_q, len_q;
  logic        ok_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cmd_q   <= trcl_pkg::cmd_e'(in_cmd_i);
      id_q    <= in_id_i;
      first_q <= in_first_i;
      cnt_q   <= in_cnt_i;
      off_q   <= in_off_i;
      len_q   <= in_len_i;
      ok_q    <= in_ok_i;
    end
  end

  // Descriptor table.
  logic [ND-1:0] ent_vld_q, ent_term_q;
  logic [31:0]   ent_key_q   [ND];
  logic [6:0]    ent_first_q [ND];
  logic [6:0]    ent_span_q  [ND];
  logic [trcl_pkg::TallyW-1:0] acc_tally_q, term_tally_q;

  // Lookup results.
  logic                          hit, dup_any, ovl, free_any, range_bad;
  logic [trcl_pkg::DescIdxW-1:0] hit_idx, free_idx;
  logic [6:0]                    a_minus_first;
  logic [32:0]                   new_end;
  logic [7:0]                    ent_end;

  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    ovl      = 1'b0;
    ent_end  = '0;
    new_end  = {1'b0, first_q} + {1'b0, cnt_q};
    for (int i = 0; i < ND; i++) begin
      if (ent_vld_q[i] && ent_key_q[i] == id_q && !hit) begin
        hit     = 1'b1;
        hit_idx = trcl_pkg::DescIdxW'(i);
      end
      if (!ent_vld_q[i] && !free_any) begin
        free_any = 1'b1;
        free_idx = trcl_pkg::DescIdxW'(i);
      end
      ent_end = {1'b0, ent_first_q[i]} + {1'b0, ent_span_q[i]};
      if (ent_vld_q[i] && first_q < {24'b0, ent_end} &&
          {26'b0, ent_first_q[i]} < new_end) begin
        ovl = 1'b1;
      end
    end
    dup_any       = hit;
    a_minus_first = a_eff - first_q[6:0];
    range_bad     = (cnt_q == 32'd0) || (first_q >= {25'b0, a_eff}) ||
                    (cnt_q > {25'b0, a_minus_first});
  end

  logic                          hit_q, acc_ok_q;
  logic [trcl_pkg::DescIdxW-1:0] hit_idx_q, free_idx_q;
  logic [6:0]                    hfirst_q, hspan_q;
  logic                          acc_now;

  assign acc_now = cmd_i.exec && cmd_q == trcl_pkg::CMD_ACCEPT && acc_ok_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      hit_q      <= hit;
      hit_idx_q  <= hit_idx;
      hfirst_q   <= ent_first_q[hit_idx];
      hspan_q    <= ent_span_q[hit_idx];
      free_idx_q <= free_idx;
      acc_ok_q   <= !range_bad && !dup_any && !ovl && free_any;
    end else if (acc_now) begin
      // The new descriptor is the one that the result reports on.
      hit_q     <= 1'b1;
      hit_idx_q <= free_idx_q;
      hfirst_q  <= first_q[6:0];
      hspan_q   <= cnt_q[6:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_now) begin
      ent_key_q[free_idx_q]   <= id_q;
      ent_first_q[free_idx_q] <= first_q[6:0];
      ent_span_q[free_idx_q]  <= cnt_q[6:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q    <= '0;
      ent_term_q   <= '0;
      acc_tally_q  <= '0;
      term_tally_q <= '0;
    end else if (cmd_i.exec) begin
      unique case (cmd_q)
        trcl_pkg::CMD_ACCEPT: begin
          if (acc_ok_q) begin
            ent_vld_q[free_idx_q]  <= 1'b1;
            ent_term_q[free_idx_q] <= 1'b0;
            if (acc_tally_q != '1) acc_tally_q <= acc_tally_q + 1'b1;
          end
        end
        trcl_pkg::CMD_TERMINAL: begin
          if (hit_q && !ent_term_q[hit_idx_q]) begin
            ent_term_q[hit_idx_q] <= 1'b1;
            if (term_tally_q != '1) term_tally_q <= term_tally_q + 1'b1;
          end
        end
        trcl_pkg::CMD_CLEAR: begin
          acc_tally_q  <= '0;
          term_tally_q <= '0;
        end
        default: ;
      endcase
    end
  end

  // Burst limits and byte walk.
  logic [17:0] prod_p, prod_q, prod_t;
  logic [16:0] p_q, q_q, tot_q;
  logic [19:0] lo_q;
  logic [20:0] hi_q, hi_d, off_end;
  logic [trcl_pkg::PosW-1:0]    c_q;
  logic [trcl_pkg::TokIdxW-1:0] t_q;
  logic [trcl_pkg::CntW-1:0]    w_q;

  assign prod_p  = {11'b0, hfirst_q} * {7'b0, b_eff};
  assign prod_q  = {11'b0, hspan_q} * {7'b0, b_eff};
  assign prod_t  = {11'b0, a_eff} * {7'b0, b_eff};
  assign off_end = {1'b0, off_q} + {1'b0, len_q};

  always_comb begin
    hi_d = {4'b0, p_q} + {4'b0, q_q};
    if (off_end < hi_d) hi_d = off_end;
    if ({4'b0, tot_q} < hi_d) hi_d = {4'b0, tot_q};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.bmul) begin
      p_q   <= prod_p[16:0];
      q_q   <= prod_q[16:0];
      tot_q <= prod_t[16:0];
    end
    if (cmd_i.blim) begin
      lo_q <= ({3'b0, p_q} > off_q) ? {3'b0, p_q} : off_q;
      hi_q <= hi_d;
      c_q  <= p_q;
      t_q  <= hfirst_q[5:0];
      w_q  <= '0;
    end else if (cmd_i.adv) begin
      c_q <= c_q + 1'b1;
      if (w_q == b_eff - 1'b1) begin
        w_q <= '0;
        t_q <= t_q + 1'b1;
      end else begin
        w_q <= w_q + 1'b1;
      end
    end
  end

  // Byte map memory, one row of 64 bytes per word.
  logic [63:0] map_mem [1 << trcl_pkg::RowW];
  logic [63:0] map_rd_q;
  logic [trcl_pkg::RowW-1:0] clr_row_q;
  logic map_bit;

  assign map_bit = map_rd_q[c_q[trcl_pkg::BitW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_row_q <= '0;
    end else if (cmd_i.clr_row) begin
      clr_row_q <= clr_row_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_row) begin
      map_mem[clr_row_q] <= '0;
    end else if (cmd_i.bwr && !map_bit) begin
      map_mem[c_q[15:6]] <= map_rd_q | (64'd1 << c_q[trcl_pkg::BitW-1:0]);
    end
    if (cmd_i.brd) map_rd_q <= map_mem[c_q[15:6]];
  end

  // Commit count memory; entries never written read as zero.
  logic [trcl_pkg::CntW-1:0]    cnt_mem [NT];
  logic [trcl_pkg::CntW-1:0]    cnt_rd_q, cnt_bwr, cnt_sw;
  logic [NT-1:0]                cnt_vld_q;
  logic [trcl_pkg::TokIdxW-1:0] tcnt_q, sw_t_q, cnt_addr;
  logic                         sw_v_q;

  assign cnt_addr = cmd_i.sweep_rd ? tcnt_q : t_q;
  assign cnt_bwr  = cnt_vld_q[t_q] ? cnt_rd_q : '0;
  assign cnt_sw   = cnt_vld_q[sw_t_q] ? cnt_rd_q : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.brd || cmd_i.sweep_rd) cnt_rd_q <= cnt_mem[cnt_addr];
    if (cmd_i.bwr && !map_bit) begin
      cnt_mem[t_q] <= (cnt_bwr == '1) ? cnt_bwr : cnt_bwr + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
    end else if (cmd_i.bwr && !map_bit) begin
      cnt_vld_q[t_q] <= 1'b1;
    end
  end

  // Sweep over all tokens to rebuild the bitmap and the prefix.
  logic [NT-1:0] fullv_q, bitmap_q;
  logic [6:0]    prefix_q;
  logic          run_q, sw_full, sw_in;

  assign sw_full = (cnt_sw == b_eff);
  assign sw_in   = ({1'b0, sw_t_q} < a_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_v_q <= 1'b0;
    end else begin
      sw_v_q <= cmd_i.sweep_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      tcnt_q   <= '0;
      prefix_q <= '0;
      run_q    <= 1'b1;
    end else begin
      if (cmd_i.sweep_rd) tcnt_q <= tcnt_q + 1'b1;
      if (sw_v_q) begin
        fullv_q[sw_t_q]  <= sw_full;
        bitmap_q[sw_t_q] <= sw_full && sw_in;
        if (run_q && sw_full && sw_in) prefix_q <= prefix_q + 1'b1;
        else run_q <= 1'b0;
      end
    end
    if (cmd_i.sweep_rd) sw_t_q <= tcnt_q;
  end

  // Result.
  logic [NT-1:0] rng_mask;
  logic [7:0]    h_end;
  logic          done;
  logic [4:0]    outstanding;

  always_comb begin
    h_end       = {1'b0, hfirst_q} + {1'b0, hspan_q};
    outstanding = '0;
    for (int t = 0; t < NT; t++) begin
      rng_mask[t] = (8'(t) >= {1'b0, hfirst_q}) && (8'(t) < h_end);
    end
    for (int i = 0; i < ND; i++) begin
      outstanding = outstanding + 5'(ent_vld_q[i] && !ent_term_q[i]);
    end
    done = hit_q && ((fullv_q | ~rng_mask) == '1);
  end

  logic        out_v_q;
  logic [87:0] out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= {bitmap_q, term_tally_q, acc_tally_q, prefix_q, outstanding, done,
                (cmd_q == trcl_pkg::CMD_ACCEPT) && acc_ok_q};
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  assign stat_o.clr_last   = (clr_row_q == '1);
  assign stat_o.is_burst   = (cmd_q == trcl_pkg::CMD_BURST);
  assign stat_o.burst_go   = hit_q && ok_q && (b_eff != '0);
  assign stat_o.c_end      = ({4'b0, c_q} >= hi_q);
  assign stat_o.c_in       = ({4'b0, c_q} >= {1'b0, lo_q});
  assign stat_o.sweep_last = (tcnt_q == '1);
  assign stat_o.out_busy   = out_v_q && !m_axis_tready;

endmodule

// ----- rtl/token_range_commit_ledger_top.sv -----
// Top level of the token range commit ledger: stream ports, configuration port and checks.
//
// One result per item. After reset the block clears every row of the byte map
// (tready stays low; configuration writes are taken). Every command ends with the 64-token
// sweep of the commit count memory that rebuilds the bitmap and prefix, and tready stays
// low until the result is loaded; a burst first walks every byte between the descriptor's
// start and the clipped end, with a byte map read-modify-write for each byte inside the
// clipped range. The next item is taken while a finished result waits on the output.
module token_range_commit_ledger_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [0:0]   cfg_idx_i,
  input  logic [10:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // descriptor key, range_first_token, range_token_count, burst_offset, burst_length,
  // burst_ok, zero fill
  input  logic [143:0] s_axis_tdata,
  // command
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // accepted, descriptor_done, outstanding_count, complete_prefix,
  // accepts_since_clear, terminals_since_clear, token_done_bitmap
  output logic [87:0]  m_axis_tdata
);

  trcl_pkg::ctrl_cmd_t  cmd;
  trcl_pkg::dp_status_t stat;

  trcl_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  trcl_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_cmd_i     (s_axis_tuser),
    .in_id_i      (s_axis_tdata[31:0]),
    .in_first_i   (s_axis_tdata[63:32]),
    .in_cnt_i     (s_axis_tdata[95:64]),
    .in_off_i     (s_axis_tdata[115:96]),
    .in_len_i     (s_axis_tdata[135:116]),
    .in_ok_i      (s_axis_tdata[136]),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .m_axis_tready(m_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tdata (m_axis_tdata)
  );

  // A freshly accepted descriptor is never terminal, so it is outstanding.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!m_axis_tdata[0] || m_axis_tdata[6:2] != 5'd0))
    else $error("accepted result with no outstanding descriptor");

  // Bit zero of the bitmap and a nonzero prefix go together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[24] == (m_axis_tdata[13:7] != 7'd0)))
    else $error("prefix disagrees with token bitmap");

  // An accepted transaction starts work; no second one in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while an item is in progress");

endmodule

// ----- test/tb_token_range_commit_ledger_top.sv -----
// Testbench for the token range commit ledger: directed and random commands checked against a ledger predictor.
module tb_token_range_commit_ledger_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    bit        accepted;
    bit        done;
    bit [4:0]  outstanding;
    bit [6:0]  prefix;
    bit [4:0]  accepts;
    bit [4:0]  terminals;
    bit [63:0] bitmap;
  } ledger_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [0:0]   cfg_idx_i = '0;
  logic [10:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [87:0]  m_axis_tdata;

  token_range_commit_ledger_top u_top (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Ledger mirror.
  bit        led_valid[trcl_pkg::MaxDesc];
  bit        led_term[trcl_pkg::MaxDesc];
  bit [31:0] led_key[trcl_pkg::MaxDesc];
  bit [6:0]  led_first[trcl_pkg::MaxDesc];
  bit [6:0]  led_span[trcl_pkg::MaxDesc];
  bit        written_map[trcl_pkg::MaxTokens*trcl_pkg::MaxTokenBytes];
  bit [10:0] commit_cnt[trcl_pkg::MaxTokens];
  bit [4:0]  accept_tally, terminal_tally;
  bit [6:0]  tokens_reg = 7'd64;
  bit [10:0] bytes_reg = 11'd64;

  ledger_result_t expected_results[$];
  int error_count = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  function automatic longint eff_tokens();
    return (tokens_reg > trcl_pkg::MaxTokens) ? trcl_pkg::MaxTokens : tokens_reg;
  endfunction

  function automatic longint eff_bytes();
    return (bytes_reg > trcl_pkg::MaxTokenBytes) ? trcl_pkg::MaxTokenBytes : bytes_reg;
  endfunction

  function automatic int find_desc(bit [31:0] key);
    for (int i = 0; i < trcl_pkg::MaxDesc; i++)
      if (led_valid[i] && led_key[i] == key) return i;
    return -1;
  endfunction

  function automatic bit token_full(longint t);
    return commit_cnt[t % trcl_pkg::MaxTokens] == eff_bytes();
  endfunction

  function automatic bit try_accept(bit [31:0] key, longint first, longint count);
    longint a;
    int slot;
    a = eff_tokens();
    slot = -1;
    if (count == 0 || first >= a || count > a - first) return 1'b0;
    if (find_desc(key) >= 0) return 1'b0;
    for (int i = 0; i < trcl_pkg::MaxDesc; i++) begin
      if (led_valid[i]) begin
        if (first < led_first[i] + led_span[i] && led_first[i] < first + count) return 1'b0;
      end else if (slot < 0) begin
        slot = i;
      end
    end
    if (slot < 0) return 1'b0;
    led_valid[slot] = 1'b1;
    led_key[slot]   = key;
    led_first[slot] = first[6:0];
    led_span[slot]  = count[6:0];
    led_term[slot]  = 1'b0;
    if (accept_tally < 31) accept_tally++;
    return 1'b1;
  endfunction

  function automatic void apply_burst(bit [31:0] key, longint offset, longint length, bit ok);
    int i;
    longint b, lo, hi, t;
    i = find_desc(key);
    b = eff_bytes();
    if (i < 0 || !ok || b == 0) return;
    lo = led_first[i] * b;
    hi = lo + led_span[i] * b;
    if (offset > lo) lo = offset;
    if (offset + length < hi) hi = offset + length;
    if (eff_tokens() * b < hi) hi = eff_tokens() * b;
    for (longint c = lo; c < hi; c++) begin
      t = c / b;
      if (c >= trcl_pkg::MaxTokens * trcl_pkg::MaxTokenBytes || t >= trcl_pkg::MaxTokens)
        break;
      if (!written_map[c]) begin
        written_map[c] = 1'b1;
        if (commit_cnt[t] < 2047) commit_cnt[t]++;
      end
    end
  endfunction

  function automatic ledger_result_t ledger_step(trcl_pkg::cmd_e cmd, bit [143:0] data);
    ledger_result_t r;
    bit [31:0] key;
    int i;
    bit all_full;
    key = data[31:0];
    r = '0;
    case (cmd)
      trcl_pkg::CMD_ACCEPT:
        r.accepted = try_accept(key, longint'(data[63:32]), longint'(data[95:64]));
      trcl_pkg::CMD_BURST:
        apply_burst(key, longint'(data[115:96]), longint'(data[135:116]), data[136]);
      trcl_pkg::CMD_TERMINAL: begin
        i = find_desc(key);
        if (i >= 0 && !led_term[i]) begin
          led_term[i] = 1'b1;
          if (terminal_tally < 31) terminal_tally++;
        end
      end
      default: begin
        accept_tally = '0;
        terminal_tally = '0;
      end
    endcase
    for (int k = 0; k < trcl_pkg::MaxDesc; k++)
      if (led_valid[k] && !led_term[k]) r.outstanding++;
    while (r.prefix < eff_tokens() && token_full(r.prefix)) r.prefix++;
    for (int t = 0; t < eff_tokens(); t++)
      if (token_full(t)) r.bitmap[t] = 1'b1;
    i = find_desc(key);
    all_full = (i >= 0);
    if (i >= 0)
      for (int k = 0; k < led_span[i]; k++)
        if (!token_full(led_first[i] + k)) all_full = 1'b0;
    r.done = all_full;
    r.accepts = accept_tally;
    r.terminals = terminal_tally;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch in %s: got %0h, expected %0h", what, got, want);
    error_count++;
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    ledger_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.accepted    = m_axis_tdata[0];
      got.done        = m_axis_tdata[1];
      got.outstanding = m_axis_tdata[6:2];
      got.prefix      = m_axis_tdata[13:7];
      got.accepts     = m_axis_tdata[18:14];
      got.terminals   = m_axis_tdata[23:19];
      got.bitmap      = m_axis_tdata[87:24];
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        want = expected_results.pop_front();
        if (got.accepted != want.accepted) report_mismatch("accepted", got.accepted, want.accepted);
        if (got.done != want.done) report_mismatch("descriptor_done", got.done, want.done);
        if (got.outstanding != want.outstanding)
          report_mismatch("outstanding_count", got.outstanding, want.outstanding);
        if (got.prefix != want.prefix) report_mismatch("complete_prefix", got.prefix, want.prefix);
        if (got.accepts != want.accepts)
          report_mismatch("accepts_since_clear", got.accepts, want.accepts);
        if (got.terminals != want.terminals)
          report_mismatch("terminals_since_clear", got.terminals, want.terminals);
        if (got.bitmap != want.bitmap)
          report_mismatch("token_done_bitmap", got.bitmap, want.bitmap);
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req <= 1'b0;
      hold_left <= 900;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_item(trcl_pkg::cmd_e cmd, bit [31:0] id, bit [31:0] first,
                           bit [31:0] count, bit [19:0] offset, bit [19:0] length, bit ok);
    bit [143:0] data;
    data = {7'b0, ok, length, offset, count, first, id};
    @(posedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) @(posedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_results.insert(expected_results.size(), ledger_step(cmd, data));
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic write_reg(trcl_pkg::reg_e idx, bit [10:0] value);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == trcl_pkg::REG_TOKENS) tokens_reg = value[6:0];
    else bytes_reg = value;
  endtask

  task automatic test_directed();
    write_reg(trcl_pkg::REG_TOKENS, 11'd8);
    write_reg(trcl_pkg::REG_BYTES, 11'd4);
    send_item(trcl_pkg::CMD_ACCEPT, 32'd1, 32'd0, 32'd0, '0, '0, 1'b0);
    send_item(trcl_pkg::CMD_ACCEPT, 32'd1, 32'd7, 32'd2, '0, '0, 1'b0);
    send_item(trcl_pkg::CMD_ACCEPT, 32'd1, 32'hFFFF_FFFF, 32'd1, '0, '0, 1'b0);
    send_item(trcl_pkg::CMD_ACCEPT, 32'd1, 32'd0, 32'hFFFF_FFFF, '0, '0, 1'b0);
    send_item(trcl_pkg::CMD_ACCEPT, 32'd1, 32'd0, 32'd2, '0, '0, 1'b0);
    send_item(trcl_pkg::CMD_ACCEPT, 32'd1, 32'd4, 32'd1, '0, '0, 1'b0);
    send_item(trcl_pkg::CMD_ACCEPT, 32'd2, 32'd1, 32'd2, '0, '0, 1'b0);
    send_item(trcl_pkg::CMD_ACCEPT, 32'hFFFF_FFFF, 32'd2, 32'd1, '0, '0, 1'b0);
    send_item(trcl_pkg::CMD_BURST, 32'd1, '0, '0, 20'd0, 20'd8, 1'b0);
    send_item(trcl_pkg::CMD_BURST, 32'd77, '0, '0, 20'd0, 20'd8, 1'b1);
    send_item(trcl_pkg::CMD_BURST, 32'd1, '0, '0, 20'd2, 20'd3, 1'b1);
    send_item(trcl_pkg::CMD_BURST, 32'd1, '0, '0, 20'd0, 20'hFFFFF, 1'b1);
    send_item(trcl_pkg::CMD_BURST, 32'hFFFF_FFFF, '0, '0, 20'hFFFFF, 20'hFFFFF, 1'b1);
    send_item(trcl_pkg::CMD_BURST, 32'hFFFF_FFFF, '0, '0, 20'd6, 20'd100, 1'b1);
    send_item(trcl_pkg::CMD_TERMINAL, 32'd1, '0, '0, '0, '0, 1'b0);
    send_item(trcl_pkg::CMD_TERMINAL, 32'd1, '0, '0, '0, '0, 1'b0);
    send_item(trcl_pkg::CMD_TERMINAL, 32'd55, '0, '0, '0, '0, 1'b0);
    send_item(trcl_pkg::CMD_CLEAR, 32'd1, '0, '0, '0, '0, 1'b0);
    // A region of zero tokens rejects every accept; zero bytes per token completes every token with no committed bytes.
    write_reg(trcl_pkg::REG_TOKENS, 11'd0);
    send_item(trcl_pkg::CMD_ACCEPT, 32'd3, 32'd0, 32'd1, '0, '0, 1'b0);
    write_reg(trcl_pkg::REG_TOKENS, 11'd127);
    write_reg(trcl_pkg::REG_BYTES, 11'd0);
    send_item(trcl_pkg::CMD_BURST, 32'd1, '0, '0, 20'd0, 20'd8, 1'b1);
    send_item(trcl_pkg::CMD_ACCEPT, 32'd3, 32'd63, 32'd1, '0, '0, 1'b0);
    // Largest token size: short bursts into a one-token range.
    write_reg(trcl_pkg::REG_BYTES, 11'd2047);
    send_item(trcl_pkg::CMD_BURST, 32'd3, '0, '0, 20'd64512, 20'd700, 1'b1);
    send_item(trcl_pkg::CMD_BURST, 32'd3, '0, '0, 20'd65000, 20'd600, 1'b1);
    send_item(trcl_pkg::CMD_ACCEPT, 32'd4, 32'd64, 32'd1, '0, '0, 1'b0);
  endtask

  task automatic test_random(int n);
    bit [31:0] pool[8];
    trcl_pkg::cmd_e cmd;
    bit [31:0] id, first, count;
    bit [19:0] offset, length;
    int sel, region;
    for (int k = 0; k < 8; k++) pool[k] = $urandom;
    pool[0] = 32'd2;
    write_reg(trcl_pkg::REG_TOKENS, 11'($urandom_range(64, 16)));
    write_reg(trcl_pkg::REG_BYTES, 11'($urandom_range(8, 1)));
    region = int'(eff_tokens() * eff_bytes());
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(99);
      id = ($urandom_range(9) == 0) ? $urandom : pool[$urandom_range(7)];
      first = $urandom_range(eff_tokens() - 1);
      count = $urandom_range(3, 1);
      offset = 20'($urandom_range(region));
      length = 20'($urandom_range(4 * eff_bytes()));
      if ($urandom_range(9) == 0) begin
        first = $urandom;
        count = $urandom;
        offset = 20'($urandom);
        length = 20'($urandom);
      end
      if (sel < 10) cmd = trcl_pkg::CMD_ACCEPT;
      else if (sel < 80) cmd = trcl_pkg::CMD_BURST;
      else if (sel < 90) cmd = trcl_pkg::CMD_TERMINAL;
      else cmd = trcl_pkg::CMD_CLEAR;
      send_item(cmd, id, first, count, offset, length, $urandom_range(99) < 85);
    end
  endtask

  task automatic test_backpressure();
    hold_req <= 1'b1;
    for (int k = 0; k < 8; k++)
      send_item(trcl_pkg::CMD_BURST, 32'd2, '0, '0, 20'($urandom_range(64)), 20'd8, 1'b1);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    tx_idle_pct = 30;
    rx_idle_pct = 73;
    test_random(600);
    tx_idle_pct = 73;
    rx_idle_pct = 30;
    test_random(600);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_backpressure();
    test_random(620);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
